// ===== rtl/pattern_search_case_fold_defines.svh =====
// Assertion helpers for the pattern search block
`ifndef PATTERN_SEARCH_CASE_FOLD_DEFINES_SVH
`define PATTERN_SEARCH_CASE_FOLD_DEFINES_SVH

// same-cycle implication, reset masked
`define PSCF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pscf assertion failed");

// next-cycle implication, reset masked
`define PSCF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pscf assertion failed");

`endif

// ===== rtl/pscf_pkg.sv =====
package pscf_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int INDEX_BITS  = 16;
    localparam int LEN_BITS    = $clog2(PATTERN_MAX + 1);
    localparam int POS_BITS    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CFG_WORD    = 64;
    localparam int CFG_IDX     = 3;
    localparam int PAT_WORDS   = (PATTERN_MAX * 8 + CFG_WORD - 1) / CFG_WORD;

    localparam logic [7:0] FOLD_MASK = 8'hDF;

    typedef enum logic [CFG_IDX-1:0] {
        REG_PATTERN_0  = 3'd0,
        REG_PATTERN_1  = 3'd1,
        REG_PATTERN_2  = 3'd2,
        REG_PATTERN_3  = 3'd3,
        REG_LENGTH     = 3'd4,
        REG_DIRECTION  = 3'd5,
        REG_MATCH_CASE = 3'd6
    } cfg_reg_t;

    typedef logic [PATTERN_MAX-1:0][7:0] window_t;
    typedef logic [PATTERN_MAX-1:0][7:0] pattern_t;
    typedef logic [INDEX_BITS-1:0]       index_t;
    typedef logic [LEN_BITS-1:0]         len_t;

    typedef struct packed {
        len_t len;
        logic down;
        logic match_case;
    } mode_t;

    function automatic logic [7:0] fold(input logic [7:0] b, input logic exact);
        logic [7:0] r;
        r = b;
        if (!exact && (b inside {[8'h61:8'h7A]}))
        begin
            r = b & FOLD_MASK;
        end
        return r;
    endfunction

endpackage

// ===== rtl/pscf_match.sv =====
module pscf_match (
    input  pscf_pkg::window_t win,
    input  pscf_pkg::pattern_t pat,
    input  pscf_pkg::mode_t   mode,
    output logic              hit
);
    import pscf_pkg::*;

    logic [PATTERN_MAX-1:0] eq;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cmp
        logic [POS_BITS-1:0] rev;
        logic [7:0]          w;
        assign rev = POS_BITS'(mode.len - len_t'(1) - len_t'(k));
        assign w   = mode.down ? win[rev] : win[k];
        assign eq[k] = (len_t'(k) >= mode.len)
                     || (fold(w, mode.match_case) == fold(pat[k], mode.match_case));
    end

    assign hit = &eq;

endmodule

// ===== rtl/pattern_search_case_fold.sv =====
// A text word is registered in the input register when accepted, and its result word in the result register.
// Throughput: one text word per cycle while no held result word stalls it; the window compare is one registered pass.
// A result word held by m_tready low stalls the compare, and s_tready then follows m_tready.
// Reset (rst_n low, async): pipeline empty, window count zero, search idle,
// pattern zero, length 1, search down, exact case.
`include "pattern_search_case_fold_defines.svh"

module pattern_search_case_fold (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pscf_pkg::CFG_IDX-1:0]  cfg_index,
    input  logic [pscf_pkg::CFG_WORD-1:0] cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,  // text_byte[7:0], byte_index[23:8]
    input  logic                          s_tuser,  // first_byte
    input  logic                          s_tlast,  // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,  // match_start[15:0], match_end[32:16]
    output logic                          m_tuser   // found
);
    import pscf_pkg::*;

    logic [PAT_WORDS-1:0][CFG_WORD-1:0] pattern_reg;
    len_t       length_reg;
    logic       down_reg;
    logic       case_reg;

    logic       in_valid_reg;
    logic [7:0] text_reg;
    index_t     idx_reg;
    logic       first_reg;
    logic       last_reg;

    window_t    win_reg, win_next;
    len_t       seen_reg, seen_next;
    logic       done_reg, done_next;

    logic       out_valid_reg;
    logic       found_reg;
    index_t     start_reg, start_next;
    logic [INDEX_BITS:0] end_reg, end_next;

    pattern_t   pat;
    mode_t      mode;
    len_t       seen_base;
    logic       advance, active, hit, res_load;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= len_t'(1);
            down_reg    <= 1'b1;
            case_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_0:  pattern_reg[0] <= cfg_data;
                REG_PATTERN_1:  pattern_reg[1] <= cfg_data;
                REG_PATTERN_2:  pattern_reg[2] <= cfg_data;
                REG_PATTERN_3:  pattern_reg[3] <= cfg_data;
                REG_LENGTH:     length_reg <= cfg_data[LEN_BITS-1:0];
                REG_DIRECTION:  down_reg <= cfg_data[0];
                REG_MATCH_CASE: case_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign pat = pattern_t'(pattern_reg);

    always_comb
    begin
        mode.len = length_reg;
        if (length_reg == '0)
        begin
            mode.len = len_t'(1);
        end
        else if (length_reg > len_t'(PATTERN_MAX))
        begin
            mode.len = len_t'(PATTERN_MAX);
        end
        mode.down       = down_reg;
        mode.match_case = case_reg;
    end

    // input register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            text_reg  <= s_tdata[7:0];
            idx_reg   <= s_tdata[23:8];
            first_reg <= s_tuser;
            last_reg  <= s_tlast;
        end
    end

    // window and compare
    assign seen_base = first_reg ? '0 : seen_reg;
    assign active    = first_reg || !done_reg;
    assign win_next  = {win_reg[PATTERN_MAX-2:0], text_reg};

    pscf_match u_match (
        .win  (win_next),
        .pat  (pat),
        .mode (mode),
        .hit  (hit)
    );

    always_comb
    begin
        seen_next = (seen_base < len_t'(PATTERN_MAX)) ? seen_base + len_t'(1) : seen_base;
        res_load  = advance && active && ((hit && (seen_next >= mode.len)) || last_reg);
        done_next = done_reg;
        if (advance && active)
        begin
            done_next = res_load ? 1'b1 : 1'b0;
        end
        start_next = mode.down ? index_t'(idx_reg - index_t'(mode.len - len_t'(1))) : idx_reg;
        end_next   = {1'b0, start_next} + (INDEX_BITS+1)'(mode.len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= done_next;
            if (advance && active)
            begin
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && active)
        begin
            win_reg <= win_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            if (hit && (seen_next >= mode.len))
            begin
                found_reg <= 1'b1;
                start_reg <= start_next;
                end_reg   <= end_next;
            end
            else
            begin
                found_reg <= 1'b0;
                start_reg <= '0;
                end_reg   <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {7'b0, end_reg, start_reg};

    `PSCF_ASSERT_NOW(a_not_found_zero, m_tvalid && !m_tuser, m_tdata == '0)
    `PSCF_ASSERT_NEXT(a_result_ends_search, res_load, done_reg && m_tvalid)
    `PSCF_ASSERT_NOW(a_seen_bounded, 1'b1, seen_reg <= len_t'(PATTERN_MAX))

endmodule
